// File: rtl/core/tcch_pkg.sv
// Shared types, constants and the arctangent table for the tilt-compensated compass.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package tcch_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int MAG_W            = SAMPLE_BITS + 1;
    localparam int ALPHA_W          = 9;
    localparam int CFG_ADDR_W       = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int IN_DATA_W        = 6 * SAMPLE_BITS;
    localparam int HEADING_W        = 15;
    localparam int OUT_DATA_W       = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam logic [ALPHA_W-1:0] MAG_ALPHA_RST = 9'd102;
    localparam logic [ALPHA_W-1:0] ACC_ALPHA_RST = 9'd26;

    // Angles in 2^-22 degree.
    localparam logic signed [33:0] DEG_180 = 34'sd754974720;
    localparam logic signed [33:0] DEG_360 = 34'sd1509949440;
    localparam logic [17:0]        HD_FULL = 18'd23040;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAG_ALPHA      = 3'd0,
        REG_ACC_ALPHA      = 3'd1,
        REG_MAG_OFFSET_X   = 3'd2,
        REG_MAG_OFFSET_Y   = 3'd3,
        REG_MAG_OFFSET_Z   = 3'd4,
        REG_SENSOR_VARIANT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [ALPHA_W-1:0]           mag_alpha;
        logic [ALPHA_W-1:0]           acc_alpha;
        logic signed [CFG_DATA_W-1:0] mag_offset_x;
        logic signed [CFG_DATA_W-1:0] mag_offset_y;
        logic signed [CFG_DATA_W-1:0] mag_offset_z;
        logic                         sensor_variant;
    } t_cfg;

    // One classified sample handed from the front end to the back end.
    typedef struct packed {
        logic signed [MAG_W-1:0]       mx;
        logic signed [MAG_W-1:0]       my;
        logic signed [MAG_W-1:0]       mz;
        logic signed [SAMPLE_BITS-1:0] ax;
        logic signed [SAMPLE_BITS-1:0] ay;
        logic signed [SAMPLE_BITS-1:0] az;
        logic                          invalid;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_ABS,
        S_NORM,
        S_PRE,
        S_ROT,
        S_WRAP,
        S_DONE
    } t_back_state;

    typedef enum logic [2:0] {
        D_RYZ2,
        D_A2,
        D_X,
        D_Y,
        D_T
    } t_dest;

    // One restoring square-root step: radicand, partial remainder, partial root.
    typedef struct packed {
        logic [31:0] rad;
        logic [17:0] rem;
        logic [15:0] root;
    } t_sqrt;

    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt       o;
        logic [17:0] rem_n;
        logic [17:0] trial;
        rem_n = {s.rem[15:0], s.rad[31:30]};
        trial = {s.root, 2'b01};
        o.rad = {s.rad[29:0], 2'b00};
        if (rem_n >= trial) begin
            o.rem  = rem_n - trial;
            o.root = {s.root[14:0], 1'b1};
        end else begin
            o.rem  = rem_n;
            o.root = {s.root[14:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [27:0] atan_deg(input logic [4:0] i);
        logic [27:0] v;
        unique case (i)
            5'd0:    v = 28'd188743680;
            5'd1:    v = 28'd111421900;
            5'd2:    v = 28'd58872272;
            5'd3:    v = 28'd29884485;
            5'd4:    v = 28'd15000234;
            5'd5:    v = 28'd7507429;
            5'd6:    v = 28'd3754631;
            5'd7:    v = 28'd1877430;
            5'd8:    v = 28'd938729;
            5'd9:    v = 28'd469366;
            5'd10:   v = 28'd234683;
            5'd11:   v = 28'd117342;
            5'd12:   v = 28'd58671;
            5'd13:   v = 28'd29335;
            5'd14:   v = 28'd14668;
            5'd15:   v = 28'd7334;
            5'd16:   v = 28'd3667;
            5'd17:   v = 28'd1833;
            5'd18:   v = 28'd917;
            5'd19:   v = 28'd458;
            5'd20:   v = 28'd229;
            5'd21:   v = 28'd115;
            5'd22:   v = 28'd57;
            5'd23:   v = 28'd29;
            5'd24:   v = 28'd14;
            5'd25:   v = 28'd7;
            5'd26:   v = 28'd4;
            5'd27:   v = 28'd2;
            5'd28:   v = 28'd1;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/tilt_compensated_compass_heading_top.sv
// Top level of the tilt-compensated compass: configuration registers, front end,
// queue and back end. Depends on tcch_pkg, tcch_front, tcch_queue, tcch_back.
//
// Usage:
//   Slave stream: one sample per request, tdata = {acc_z, acc_y, acc_x,
//   mag_z, mag_y, mag_x}, 16 bits each, mag_x in the lowest bits.
//   Master stream: one result per sample, tdata[14:0] = heading in 1/64 degree
//   (0 .. 23039), tuser = tilt_invalid (zero filtered acceleration).
//   Config channel: i_cfg_addr selects mag_alpha, acc_alpha, mag_offset_x/y/z,
//   sensor_variant (indices 0..5); always ready, write only while idle.
//   Back end: works one sample at a time; its time per sample is set by the
//   shared multiplier sequence, the 16-step square roots, the range shifts
//   before the CORDIC and the one-iteration-per-cycle CORDIC. A zero
//   acceleration sample skips the arithmetic and goes straight to the output.
//   The front end filters and queues up to two samples while the back end is busy.
//   Reset: filters cleared, registers to their defaults, queue and output empty.
//   Stall: a result waits in the output register; the back end holds the next
//   finished result, the queue fills, then the slave side drops tready.
`default_nettype none
module tilt_compensated_compass_heading_top
    import tcch_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // config write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // sample stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]   i_s_axis_tdata,  // mag_x, mag_y, mag_z, acc_x, acc_y, acc_z
    // heading stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]       o_m_axis_tdata,  // heading[14:0], zero pad
    output logic                        o_m_axis_tuser   // tilt_invalid
);

    t_cfg  r_cfg;
    t_item w_push_item;
    t_item w_pop_item;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    logic [HEADING_W-1:0] w_heading;

    assign o_cfg_ready = 1'b1;

    // Hold register values; write the addressed one on each config request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mag_alpha      <= MAG_ALPHA_RST;
            r_cfg.acc_alpha      <= ACC_ALPHA_RST;
            r_cfg.mag_offset_x   <= '0;
            r_cfg.mag_offset_y   <= '0;
            r_cfg.mag_offset_z   <= '0;
            r_cfg.sensor_variant <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_MAG_ALPHA:      r_cfg.mag_alpha      <= i_cfg_data[ALPHA_W-1:0];
                REG_ACC_ALPHA:      r_cfg.acc_alpha      <= i_cfg_data[ALPHA_W-1:0];
                REG_MAG_OFFSET_X:   r_cfg.mag_offset_x   <= i_cfg_data;
                REG_MAG_OFFSET_Y:   r_cfg.mag_offset_y   <= i_cfg_data;
                REG_MAG_OFFSET_Z:   r_cfg.mag_offset_z   <= i_cfg_data;
                REG_SENSOR_VARIANT: r_cfg.sensor_variant <= i_cfg_data[0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    tcch_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    tcch_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_pop_item)
    );

    tcch_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_variant (r_cfg.sensor_variant),
        .i_empty   (w_empty),
        .i_item    (w_pop_item),
        .o_pop     (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_heading (w_heading),
        .o_invalid (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = OUT_DATA_W'(w_heading);

endmodule
`default_nettype wire

// File: rtl/core/tcch_front.sv
// Front end: takes samples, runs the six low-pass filters, subtracts hard-iron
// offsets and flags a zero acceleration vector. Depends on tcch_pkg.
`default_nettype none
module tcch_front
    import tcch_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [IN_DATA_W-1:0] i_data,
    input  wire logic                 i_full,
    output logic                      o_push,
    output t_item                     o_item
);

    typedef logic signed [SAMPLE_BITS-1:0] t_smp;

    function automatic t_smp lpf(input t_smp raw, input t_smp old,
                                 input logic [ALPHA_W-1:0] alpha);
        logic [ALPHA_W-1:0] a;
        logic [ALPHA_W-1:0] b;
        logic signed [26:0] acc;
        logic signed [26:0] q;
        a   = (alpha > 9'd256) ? 9'd256 : alpha;
        b   = 9'd256 - a;
        acc = 27'(raw) * 27'($signed({1'b0, a})) + 27'(old) * 27'($signed({1'b0, b}));
        q   = acc >>> 8;
        // truncate toward zero
        if (acc[26] && (acc[7:0] != 8'd0)) begin
            q = q + 27'sd1;
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    t_smp r_filt [6];
    t_smp n_filt [6];
    logic w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_filt[k] = lpf(i_data[k*SAMPLE_BITS +: SAMPLE_BITS], r_filt[k],
                            (k < 3) ? i_cfg.mag_alpha : i_cfg.acc_alpha);
        end
        o_item.mx      = MAG_W'(n_filt[0]) - MAG_W'(i_cfg.mag_offset_x);
        o_item.my      = MAG_W'(n_filt[1]) - MAG_W'(i_cfg.mag_offset_y);
        o_item.mz      = MAG_W'(n_filt[2]) - MAG_W'(i_cfg.mag_offset_z);
        o_item.ax      = n_filt[3];
        o_item.ay      = n_filt[4];
        o_item.az      = n_filt[5];
        o_item.invalid = (n_filt[3] == '0) && (n_filt[4] == '0) && (n_filt[5] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_filt[k] <= '0;
            end
        end else if (w_accept) begin
            for (int k = 0; k < 6; k++) begin
                r_filt[k] <= n_filt[k];
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/tcch_queue.sv
// Short queue between the front end and the back end.
// Depends on tcch_pkg for the item type.
`default_nettype none
module tcch_queue
    import tcch_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_item      o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/tcch_back.sv
// Back end: products on one shared multiplier, two square roots, range
// normalization, vectoring CORDIC, wrap and rounding, output register.
// Depends on tcch_pkg.
`default_nettype none
module tcch_back
    import tcch_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_variant,
    input  wire logic          i_empty,
    input  wire t_item         i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [HEADING_W-1:0] o_heading,
    output logic               o_invalid
);

    localparam int NSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    t_back_state r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;

    t_item              r_item, n_item;
    logic [31:0]        r_ryz2, n_ryz2;
    logic signed [51:0] r_x, n_x;
    logic signed [51:0] r_y, n_y;
    logic signed [33:0] r_t, n_t;
    logic [51:0]        r_mag_x, n_mag_x;
    logic [51:0]        r_mag_y, n_mag_y;
    logic signed [33:0] r_z, n_z;
    t_sqrt              r_sq_a, n_sq_a;
    t_sqrt              r_sq_r, n_sq_r;
    logic [HEADING_W-1:0] r_hd, n_hd;
    logic               r_inv, n_inv;
    logic               r_out_valid, n_out_valid;
    logic [HEADING_W-1:0] r_out_hd, n_out_hd;
    logic               r_out_inv, n_out_inv;

    // shared multiplier
    logic signed [33:0] w_opa;
    logic signed [17:0] w_opb;
    logic signed [51:0] w_prod;
    logic signed [51:0] w_base;
    logic signed [51:0] w_sum;
    logic               w_sub;
    t_dest              w_dest;
    logic [16:0]        w_absz;
    logic signed [51:0] w_dx;
    logic signed [51:0] w_dy;
    logic signed [33:0] w_zw;
    logic [17:0]        w_q;

    assign w_absz = r_item.az[SAMPLE_BITS-1] ? 17'(-18'(r_item.az)) : 17'(r_item.az);

    always_comb begin
        w_opa  = 34'(r_item.ay);
        w_opb  = 18'(r_item.ay);
        w_dest = D_T;
        w_base = '0;
        w_sub  = 1'b0;
        unique case (r_cnt[3:0])
            4'd0: begin
                w_opa = 34'(r_item.ay); w_opb = 18'(r_item.ay); w_dest = D_RYZ2;
            end
            4'd1: begin
                w_opa = 34'(r_item.az); w_opb = 18'(r_item.az); w_dest = D_RYZ2;
                w_base = $signed({20'd0, r_ryz2});
            end
            4'd2: begin
                w_opa = 34'(r_item.ax); w_opb = 18'(r_item.ax); w_dest = D_A2;
                w_base = $signed({20'd0, r_ryz2});
            end
            4'd3: begin
                w_opa = $signed({2'b00, r_ryz2}); w_opb = 18'(r_item.mx); w_dest = D_X;
            end
            4'd4: begin
                w_opa = 34'(r_item.mz); w_opb = 18'(r_item.ax); w_dest = D_T;
            end
            4'd5: begin
                w_opa = r_t; w_opb = $signed({2'b00, r_sq_r.root}); w_dest = D_X;
                w_base = r_x;
            end
            4'd6: begin
                w_opa = 34'(r_item.mx); w_opb = 18'(r_item.ax); w_dest = D_T;
            end
            4'd7: begin
                w_opa = r_t; w_opb = 18'(r_item.ay); w_dest = D_Y; w_sub = 1'b1;
            end
            4'd8: begin
                w_opa = 34'(r_item.my); w_opb = $signed({1'b0, w_absz}); w_dest = D_T;
            end
            4'd9: begin
                w_opa = r_t; w_opb = $signed({2'b00, r_sq_a.root}); w_dest = D_Y;
                w_base = r_y;
            end
            4'd10: begin
                w_opa = 34'(r_item.mz); w_opb = 18'(r_item.ay); w_dest = D_T;
            end
            4'd11: begin
                w_opa = r_t; w_opb = $signed({2'b00, r_sq_r.root}); w_dest = D_Y;
                w_base = r_y; w_sub = !i_variant;
            end
            default: begin
                w_opa = '0; w_opb = '0; w_dest = D_T;
            end
        endcase
        w_prod = 52'(w_opa) * 52'(w_opb);
        w_sum  = w_sub ? (w_base - w_prod) : (w_base + w_prod);
    end

    assign w_dx = r_y >>> r_cnt[4:0];
    assign w_dy = r_x >>> r_cnt[4:0];
    assign w_zw = (r_z < 0) ? (r_z + DEG_360) : ((r_z >= DEG_360) ? (r_z - DEG_360) : r_z);
    assign w_q  = 18'((w_zw + 34'sd32768) >>> 16);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_item      = r_item;
        n_ryz2      = r_ryz2;
        n_x         = r_x;
        n_y         = r_y;
        n_t         = r_t;
        n_mag_x     = r_mag_x;
        n_mag_y     = r_mag_y;
        n_z         = r_z;
        n_sq_a      = r_sq_a;
        n_sq_r      = r_sq_r;
        n_hd        = r_hd;
        n_inv       = r_inv;
        n_out_valid = r_out_valid && !i_ready;
        n_out_hd    = r_out_hd;
        n_out_inv   = r_out_inv;
        o_pop       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    n_cnt  = '0;
                    if (i_item.invalid) begin
                        n_hd    = '0;
                        n_inv   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_inv   = 1'b0;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                unique case (w_dest)
                    D_RYZ2:  n_ryz2 = w_sum[31:0];
                    D_A2:    n_sq_a = '{rad: w_sum[31:0], rem: '0, root: '0};
                    D_X:     n_x    = w_sum;
                    D_Y:     n_y    = w_sum;
                    D_T:     n_t    = w_sum[33:0];
                    default: n_t    = r_t;
                endcase
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd2) begin
                    n_sq_r  = '{rad: r_ryz2, rem: '0, root: '0};
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else if (r_cnt == 6'd11) begin
                    n_state = S_ABS;
                end
            end
            S_SQRT: begin
                n_sq_a = sqrt_step(r_sq_a);
                n_sq_r = sqrt_step(r_sq_r);
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == 6'd15) begin
                    if (r_ryz2 == '0) begin
                        // acceleration along X only: roll taken as zero
                        n_x     = (r_item.ax > 0) ? 52'(r_item.mz) : -52'(r_item.mz);
                        n_y     = 52'(r_item.my);
                        n_state = S_ABS;
                    end else begin
                        n_cnt   = 6'd3;
                        n_state = S_MUL;
                    end
                end
            end
            S_ABS: begin
                n_mag_x = r_x[51] ? 52'(-r_x) : 52'(r_x);
                n_mag_y = r_y[51] ? 52'(-r_y) : 52'(r_y);
                n_state = S_NORM;
            end
            S_NORM: begin
                // shift both until each magnitude is below 2^30
                if ((|r_mag_x[51:30]) || (|r_mag_y[51:30])) begin
                    n_mag_x = r_mag_x >> 1;
                    n_mag_y = r_mag_y >> 1;
                    n_x     = r_x >>> 1;
                    n_y     = r_y >>> 1;
                end else begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (r_x < 0) begin
                    n_x = -r_x;
                    n_y = -r_y;
                    n_z = DEG_180;
                end else begin
                    n_z = '0;
                end
                n_cnt   = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                if (r_y > 0) begin
                    n_x = r_x + w_dx;
                    n_y = r_y - w_dy;
                    n_z = r_z + $signed({6'd0, atan_deg(r_cnt[4:0])});
                end else if (r_y < 0) begin
                    n_x = r_x - w_dx;
                    n_y = r_y + w_dy;
                    n_z = r_z - $signed({6'd0, atan_deg(r_cnt[4:0])});
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(NSTEPS - 1)) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                n_hd    = (w_q >= HD_FULL) ? '0 : w_q[HEADING_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hd    = r_hd;
                    n_out_inv   = r_inv;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_ryz2    <= n_ryz2;
        r_x       <= n_x;
        r_y       <= n_y;
        r_t       <= n_t;
        r_mag_x   <= n_mag_x;
        r_mag_y   <= n_mag_y;
        r_z       <= n_z;
        r_sq_a    <= n_sq_a;
        r_sq_r    <= n_sq_r;
        r_hd      <= n_hd;
        r_inv     <= n_inv;
        r_out_hd  <= n_out_hd;
        r_out_inv <= n_out_inv;
    end

    assign o_valid   = r_out_valid;
    assign o_heading = r_out_hd;
    assign o_invalid = r_out_inv;

    a_hd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_hd < HD_FULL[HEADING_W-1:0]))
        else $error("heading out of range");

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_inv) |-> (r_out_hd == '0))
        else $error("invalid sample with nonzero heading");

    a_root_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_cnt >= 6'd3) |-> (r_sq_a.root >= r_sq_r.root))
        else $error("total magnitude below YZ magnitude");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && !i_empty))
        else $error("pop outside idle");

endmodule
`default_nettype wire
